// ===== hdl/mau_pkg.sv =====
// shared types, constants and helper functions of the mahony attitude update block
// no dependencies

package mau_pkg;

	// fraction bits of quaternion, unit vectors and rates
	localparam int QF = 30;
	localparam logic signed [63:0] ONE_Q = 64'sd1 <<< QF;
	localparam logic signed [31:0] ONE_32 = 32'(ONE_Q);
	// pi/(42000*180) in Q0.40
	localparam logic signed [63:0] GYRO_K = 64'sd456907;
	localparam int GYRO_K_BITS = 40;
	localparam int ACC_EXTRA = 15;
	localparam int KP_BITS = 24;
	// magnitude bits walked by the serial multiplier
	localparam int MUL_BITS = 34;

	// configuration register indexes
	localparam logic [2:0] CFG_GAIN_KP = 3'd0;
	localparam logic [2:0] CFG_DRIFT_X = 3'd1;
	localparam logic [2:0] CFG_DRIFT_Y = 3'd2;
	localparam logic [2:0] CFG_DRIFT_Z = 3'd3;
	localparam logic [2:0] CFG_INIT_W = 3'd4;
	localparam logic [2:0] CFG_INIT_I = 3'd5;
	localparam logic [2:0] CFG_INIT_J = 3'd6;
	localparam logic [2:0] CFG_INIT_K = 3'd7;

	localparam logic OP_LOAD = 1'b0;

	typedef struct packed {
		logic op;
		logic signed [15:0] gyro_raw_x;
		logic signed [15:0] gyro_raw_y;
		logic signed [15:0] gyro_raw_z;
		logic signed [15:0] accel_raw_x;
		logic signed [15:0] accel_raw_y;
		logic signed [15:0] accel_raw_z;
	} in_word_t;

	typedef struct packed {
		logic signed [31:0] quat_w;
		logic signed [31:0] quat_i;
		logic signed [31:0] quat_j;
		logic signed [31:0] quat_k;
	} out_word_t;

	typedef struct packed {
		logic [23:0] gain_kp;
		logic signed [15:0] drift_x;
		logic signed [15:0] drift_y;
		logic signed [15:0] drift_z;
		logic signed [31:0] init_w;
		logic signed [31:0] init_i;
		logic signed [31:0] init_j;
		logic signed [31:0] init_k;
	} cfg_regs_t;

	typedef enum logic [1:0] {
		ALU_MUL,
		ALU_DIV,
		ALU_SQRT
	} alu_op_t;

	typedef struct packed {
		logic start;
		alu_op_t op;
		logic signed [63:0] a;
		logic [63:0] b;
	} alu_req_t;

	typedef struct packed {
		logic done;
		logic signed [63:0] res;
	} alu_rsp_t;

	typedef struct packed {
		logic busy;
		logic fin;
	} seq_rsp_t;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_ISSUE,
		PH_WAIT,
		PH_HOLD
	} phase_t;

	typedef enum logic [5:0] {
		ST_GX, ST_GY, ST_GZ,
		ST_AX2, ST_AY2, ST_AZ2, ST_ASQRT,
		ST_ANX, ST_ANY, ST_ANZ,
		ST_GE0A, ST_GE0B, ST_GE1A, ST_GE1B, ST_GE2A, ST_GE2B,
		ST_E0A, ST_E0B, ST_E1A, ST_E1B, ST_E2A, ST_E2B,
		ST_W0, ST_W1, ST_W2,
		ST_D0A, ST_D0B, ST_D0C, ST_D1A, ST_D1B, ST_D1C,
		ST_D2A, ST_D2B, ST_D2C, ST_D3A, ST_D3B, ST_D3C,
		ST_Q0SQ, ST_Q1SQ, ST_Q2SQ, ST_Q3SQ, ST_QSQRT,
		ST_QN0, ST_QN1, ST_QN2, ST_QN3
	} step_t;

	function automatic logic signed [63:0] sat64(input logic signed [63:0] v,
			input logic signed [63:0] lo, input logic signed [63:0] hi);
		logic signed [63:0] r;
		r = v;
		if (v < lo) begin
			r = lo;
		end else if (v > hi) begin
			r = hi;
		end
		return r;
	endfunction

	function automatic logic [63:0] mag64(input logic signed [63:0] v);
		return v[63] ? 64'(-v) : 64'(v);
	endfunction

endpackage

// ===== hdl/mau_alu.sv =====
// serial arithmetic unit: multiply one bit, divide one bit, square root two bits per cycle
// depends on mau_pkg

module mau_alu (
	input  logic              clk,
	input  logic              arst_n,
	input  mau_pkg::alu_req_t req,
	output mau_pkg::alu_rsp_t rsp
);
	import mau_pkg::*;

	logic busy_q;
	logic done_q;
	logic [5:0] cnt_q;
	alu_op_t op_q;
	logic neg_q;
	logic [63:0] x_q;
	logic [63:0] y_q;
	logic [63:0] acc_q;
	logic [63:0] res_q;

	logic [63:0] rem_div;
	logic [63:0] rem_sq;
	logic [63:0] trial;

	always_comb begin
		rem_div = {acc_q[62:0], x_q[63]};
		rem_sq = {acc_q[61:0], x_q[63:62]};
		trial = {res_q[61:0], 2'b01};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
			op_q <= ALU_MUL;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				op_q <= req.op;
				case (req.op)
					ALU_MUL: cnt_q <= 6'(MUL_BITS - 1);
					ALU_DIV: cnt_q <= 6'd63;
					default: cnt_q <= 6'd31;
				endcase
			end else if (busy_q) begin
				if (cnt_q == 6'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q - 6'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			acc_q <= '0;
			res_q <= '0;
			case (req.op)
				ALU_MUL: begin
					x_q <= mag64(req.a);
					y_q <= mag64($signed(req.b));
					neg_q <= req.a[63] ^ req.b[63];
				end
				ALU_DIV: begin
					x_q <= mag64(req.a);
					y_q <= req.b;
					neg_q <= req.a[63];
				end
				default: begin
					x_q <= req.a;
					y_q <= req.b;
					neg_q <= 1'b0;
				end
			endcase
		end else if (busy_q) begin
			case (op_q)
				ALU_MUL: begin
					if (y_q[0]) begin
						acc_q <= acc_q + x_q;
					end
					x_q <= {x_q[62:0], 1'b0};
					y_q <= {1'b0, y_q[63:1]};
				end
				ALU_DIV: begin
					x_q <= {x_q[62:0], 1'b0};
					if (rem_div >= y_q) begin
						acc_q <= rem_div - y_q;
						res_q <= {res_q[62:0], 1'b1};
					end else begin
						acc_q <= rem_div;
						res_q <= {res_q[62:0], 1'b0};
					end
				end
				default: begin
					x_q <= {x_q[61:0], 2'b00};
					if (rem_sq >= trial) begin
						acc_q <= rem_sq - trial;
						res_q <= {res_q[62:0], 1'b1};
					end else begin
						acc_q <= rem_sq;
						res_q <= {res_q[62:0], 1'b0};
					end
				end
			endcase
		end
	end

	always_comb begin
		rsp.done = done_q;
		case (op_q)
			ALU_MUL: rsp.res = neg_q ? -$signed(acc_q) : $signed(acc_q);
			ALU_DIV: rsp.res = neg_q ? -$signed(res_q) : $signed(res_q);
			default: rsp.res = $signed(res_q);
		endcase
	end

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("alu started while busy");
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |=> !done_q) else $error("alu done longer than one cycle");
	a_fell_done: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy_q) |-> done_q) else $error("alu finished without done");
`endif

endmodule

// ===== hdl/mau_seq.sv =====
// step sequencer and working registers of one attitude update
// depends on mau_pkg and mau_alu

module mau_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  mau_pkg::in_word_t  in_word,
	input  mau_pkg::cfg_regs_t cfg,
	input  logic               out_free,
	output mau_pkg::seq_rsp_t  sr,
	output mau_pkg::out_word_t result
);
	import mau_pkg::*;

	phase_t phase_q, phase_d;
	step_t step_q;

	alu_req_t req;
	alu_rsp_t rsp;

	logic signed [31:0] q_q [4];
	logic signed [19:0] rx_q, ry_q, rz_q;
	logic signed [16:0] ax_q, ay_q, az_q;
	logic signed [31:0] g_q [3];
	logic signed [31:0] an_q [3];
	logic signed [33:0] ge_q [3];
	logic signed [34:0] e_q [3];
	logic signed [32:0] w_q [3];
	logic signed [31:0] qn_q [4];
	logic signed [63:0] acc_q;
	logic [63:0] n2_q;
	logic [32:0] rr_q;

	logic signed [63:0] res;
	logic signed [63:0] m;
	logic signed [63:0] an_val;
	logic wb;

	mau_alu u_alu (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req),
		.rsp    (rsp)
	);

	assign res = rsp.res;
	assign m = res >>> QF;
	assign an_val = (rr_q == '0) ? 64'sd0 : sat64(res, -ONE_Q, ONE_Q);
	assign wb = (phase_q == PH_WAIT) && rsp.done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
		end else begin
			phase_q <= phase_d;
		end
	end

	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			PH_IDLE: begin
				if (start) begin
					phase_d = (in_word.op == OP_LOAD) ? PH_HOLD : PH_ISSUE;
				end
			end
			PH_ISSUE: phase_d = PH_WAIT;
			PH_WAIT: begin
				if (rsp.done) begin
					phase_d = (step_q == ST_QN3) ? PH_HOLD : PH_ISSUE;
				end
			end
			PH_HOLD: begin
				if (out_free) begin
					phase_d = PH_IDLE;
				end
			end
			default: phase_d = PH_IDLE;
		endcase
		sr.busy = (phase_q != PH_IDLE);
		sr.fin = (phase_q == PH_HOLD) && out_free;
	end

	// operand select for the current step
	always_comb begin
		req.start = (phase_q == PH_ISSUE);
		req.op = ALU_MUL;
		req.a = '0;
		req.b = '0;
		case (step_q)
			ST_GX: begin req.a = -64'(ry_q); req.b = GYRO_K; end
			ST_GY: begin req.a = 64'(rx_q); req.b = GYRO_K; end
			ST_GZ: begin req.a = 64'(rz_q); req.b = GYRO_K; end
			ST_AX2: begin req.a = 64'(ax_q); req.b = 64'(ax_q); end
			ST_AY2: begin req.a = 64'(ay_q); req.b = 64'(ay_q); end
			ST_AZ2: begin req.a = 64'(az_q); req.b = 64'(az_q); end
			ST_ASQRT: begin
				req.op = ALU_SQRT;
				req.a = $signed(n2_q << (2 * ACC_EXTRA));
			end
			ST_ANX: begin
				req.op = ALU_DIV; req.a = 64'(ax_q) <<< (QF + ACC_EXTRA); req.b = 64'(rr_q);
			end
			ST_ANY: begin
				req.op = ALU_DIV; req.a = 64'(ay_q) <<< (QF + ACC_EXTRA); req.b = 64'(rr_q);
			end
			ST_ANZ: begin
				req.op = ALU_DIV; req.a = 64'(az_q) <<< (QF + ACC_EXTRA); req.b = 64'(rr_q);
			end
			ST_GE0A: begin req.a = 64'(q_q[1]); req.b = 64'(q_q[3]); end
			ST_GE0B: begin req.a = 64'(q_q[0]); req.b = 64'(q_q[2]); end
			ST_GE1A: begin req.a = 64'(q_q[2]); req.b = 64'(q_q[3]); end
			ST_GE1B: begin req.a = 64'(q_q[0]); req.b = 64'(q_q[1]); end
			ST_GE2A: begin req.a = 64'(q_q[1]); req.b = 64'(q_q[1]); end
			ST_GE2B: begin req.a = 64'(q_q[2]); req.b = 64'(q_q[2]); end
			ST_E0A: begin req.a = 64'(ge_q[1]); req.b = 64'(an_q[2]); end
			ST_E0B: begin req.a = 64'(ge_q[2]); req.b = 64'(an_q[1]); end
			ST_E1A: begin req.a = 64'(ge_q[2]); req.b = 64'(an_q[0]); end
			ST_E1B: begin req.a = 64'(ge_q[0]); req.b = 64'(an_q[2]); end
			ST_E2A: begin req.a = 64'(ge_q[0]); req.b = 64'(an_q[1]); end
			ST_E2B: begin req.a = 64'(ge_q[1]); req.b = 64'(an_q[0]); end
			ST_W0: begin req.a = $signed(64'(cfg.gain_kp)); req.b = 64'(e_q[0]); end
			ST_W1: begin req.a = $signed(64'(cfg.gain_kp)); req.b = 64'(e_q[1]); end
			ST_W2: begin req.a = $signed(64'(cfg.gain_kp)); req.b = 64'(e_q[2]); end
			ST_D0A: begin req.a = 64'(q_q[1]); req.b = 64'(w_q[0]); end
			ST_D0B: begin req.a = 64'(q_q[2]); req.b = 64'(w_q[1]); end
			ST_D0C: begin req.a = 64'(q_q[3]); req.b = 64'(w_q[2]); end
			ST_D1A: begin req.a = 64'(q_q[0]); req.b = 64'(w_q[0]); end
			ST_D1B: begin req.a = 64'(q_q[2]); req.b = 64'(w_q[2]); end
			ST_D1C: begin req.a = 64'(q_q[3]); req.b = 64'(w_q[1]); end
			ST_D2A: begin req.a = 64'(q_q[0]); req.b = 64'(w_q[1]); end
			ST_D2B: begin req.a = 64'(q_q[1]); req.b = 64'(w_q[2]); end
			ST_D2C: begin req.a = 64'(q_q[3]); req.b = 64'(w_q[0]); end
			ST_D3A: begin req.a = 64'(q_q[0]); req.b = 64'(w_q[2]); end
			ST_D3B: begin req.a = 64'(q_q[1]); req.b = 64'(w_q[1]); end
			ST_D3C: begin req.a = 64'(q_q[2]); req.b = 64'(w_q[0]); end
			ST_Q0SQ: begin req.a = 64'(qn_q[0]); req.b = 64'(qn_q[0]); end
			ST_Q1SQ: begin req.a = 64'(qn_q[1]); req.b = 64'(qn_q[1]); end
			ST_Q2SQ: begin req.a = 64'(qn_q[2]); req.b = 64'(qn_q[2]); end
			ST_Q3SQ: begin req.a = 64'(qn_q[3]); req.b = 64'(qn_q[3]); end
			ST_QSQRT: begin req.op = ALU_SQRT; req.a = $signed(n2_q); end
			ST_QN0: begin req.op = ALU_DIV; req.a = 64'(qn_q[0]) <<< QF; req.b = 64'(rr_q); end
			ST_QN1: begin req.op = ALU_DIV; req.a = 64'(qn_q[1]) <<< QF; req.b = 64'(rr_q); end
			ST_QN2: begin req.op = ALU_DIV; req.a = 64'(qn_q[2]) <<< QF; req.b = 64'(rr_q); end
			ST_QN3: begin req.op = ALU_DIV; req.a = 64'(qn_q[3]) <<< QF; req.b = 64'(rr_q); end
			default: req.op = ALU_MUL;
		endcase
	end

	// step counter and attitude state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_GX;
			q_q[0] <= ONE_32;
			q_q[1] <= '0;
			q_q[2] <= '0;
			q_q[3] <= '0;
		end else if (phase_q == PH_IDLE && start) begin
			step_q <= ST_GX;
			if (in_word.op == OP_LOAD) begin
				q_q[0] <= 32'(sat64(64'(cfg.init_w), -ONE_Q, ONE_Q));
				q_q[1] <= 32'(sat64(64'(cfg.init_i), -ONE_Q, ONE_Q));
				q_q[2] <= 32'(sat64(64'(cfg.init_j), -ONE_Q, ONE_Q));
				q_q[3] <= 32'(sat64(64'(cfg.init_k), -ONE_Q, ONE_Q));
			end
		end else if (wb) begin
			if (step_q != ST_QN3) begin
				step_q <= step_t'(step_q + 6'd1);
			end
			// zero norm keeps the stepped quaternion as it is
			case (step_q)
				ST_QN0: q_q[0] <= (rr_q == '0) ? qn_q[0] : 32'(sat64(res, -ONE_Q, ONE_Q));
				ST_QN1: q_q[1] <= (rr_q == '0) ? qn_q[1] : 32'(sat64(res, -ONE_Q, ONE_Q));
				ST_QN2: q_q[2] <= (rr_q == '0) ? qn_q[2] : 32'(sat64(res, -ONE_Q, ONE_Q));
				ST_QN3: q_q[3] <= (rr_q == '0) ? qn_q[3] : 32'(sat64(res, -ONE_Q, ONE_Q));
				default: q_q[0] <= q_q[0];
			endcase
		end
	end

	// working registers, written back once per step
	always_ff @(posedge clk) begin
		if (phase_q == PH_IDLE && start) begin
			rx_q <= (20'(in_word.gyro_raw_x) <<< 3) - 20'(cfg.drift_x);
			ry_q <= (20'(in_word.gyro_raw_y) <<< 3) - 20'(cfg.drift_y);
			rz_q <= (20'(in_word.gyro_raw_z) <<< 3) - 20'(cfg.drift_z);
			ax_q <= 17'(in_word.accel_raw_y);
			ay_q <= -17'(in_word.accel_raw_x);
			az_q <= -17'(in_word.accel_raw_z);
		end else if (wb) begin
			case (step_q)
				ST_GX: g_q[0] <= 32'(res >>> (GYRO_K_BITS - QF));
				ST_GY: g_q[1] <= 32'(res >>> (GYRO_K_BITS - QF));
				ST_GZ: g_q[2] <= 32'(res >>> (GYRO_K_BITS - QF));
				ST_AX2, ST_Q0SQ: n2_q <= 64'(res);
				ST_AY2, ST_AZ2, ST_Q1SQ, ST_Q2SQ, ST_Q3SQ: n2_q <= n2_q + 64'(res);
				ST_ASQRT, ST_QSQRT: rr_q <= 33'(res);
				ST_ANX: an_q[0] <= 32'(an_val);
				ST_ANY: an_q[1] <= 32'(an_val);
				ST_ANZ: an_q[2] <= 32'(an_val);
				ST_GE0A, ST_GE1A, ST_GE2A, ST_E0A, ST_E1A, ST_E2A,
				ST_D1A, ST_D2A, ST_D3A: acc_q <= m;
				ST_D0A: acc_q <= -m;
				ST_D0B, ST_D2B: acc_q <= acc_q - m;
				ST_D1B, ST_D3B: acc_q <= acc_q + m;
				ST_GE0B: ge_q[0] <= 34'((acc_q - m) <<< 1);
				ST_GE1B: ge_q[1] <= 34'((acc_q + m) <<< 1);
				ST_GE2B: ge_q[2] <= 34'(ONE_Q - ((acc_q + m) <<< 1));
				ST_E0B: e_q[0] <= 35'(acc_q - m);
				ST_E1B: e_q[1] <= 35'(acc_q - m);
				ST_E2B: e_q[2] <= 35'(acc_q - m);
				ST_W0: w_q[0] <= 33'(sat64(64'(g_q[0]) + (res >>> KP_BITS),
					-(ONE_Q <<< 1), ONE_Q <<< 1));
				ST_W1: w_q[1] <= 33'(sat64(64'(g_q[1]) + (res >>> KP_BITS),
					-(ONE_Q <<< 1), ONE_Q <<< 1));
				ST_W2: w_q[2] <= 33'(sat64(64'(g_q[2]) + (res >>> KP_BITS),
					-(ONE_Q <<< 1), ONE_Q <<< 1));
				ST_D0C: qn_q[0] <= 32'(sat64(64'(q_q[0]) + ((acc_q - m) >>> 1),
					-((ONE_Q <<< 1) - 1), (ONE_Q <<< 1) - 1));
				ST_D1C: qn_q[1] <= 32'(sat64(64'(q_q[1]) + ((acc_q - m) >>> 1),
					-((ONE_Q <<< 1) - 1), (ONE_Q <<< 1) - 1));
				ST_D2C: qn_q[2] <= 32'(sat64(64'(q_q[2]) + ((acc_q + m) >>> 1),
					-((ONE_Q <<< 1) - 1), (ONE_Q <<< 1) - 1));
				ST_D3C: qn_q[3] <= 32'(sat64(64'(q_q[3]) + ((acc_q - m) >>> 1),
					-((ONE_Q <<< 1) - 1), (ONE_Q <<< 1) - 1));
				default: acc_q <= acc_q;
			endcase
		end
	end

	assign result.quat_w = q_q[0];
	assign result.quat_i = q_q[1];
	assign result.quat_j = q_q[2];
	assign result.quat_k = q_q[3];

`ifndef SYNTHESIS
	a_q_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE) |-> (q_q[0] <= ONE_32 && q_q[0] >= -ONE_32
			&& q_q[1] <= ONE_32 && q_q[1] >= -ONE_32
			&& q_q[2] <= ONE_32 && q_q[2] >= -ONE_32
			&& q_q[3] <= ONE_32 && q_q[3] >= -ONE_32))
		else $error("attitude out of range");
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.done |-> phase_q == PH_WAIT) else $error("alu result outside wait");
	a_hold_kept: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_HOLD && !out_free) |=> phase_q == PH_HOLD)
		else $error("result dropped while output full");
`endif

endmodule

// ===== hdl/mahony_attitude_update.sv =====
// top level of the mahony attitude update: config registers, input accept, output register
// depends on mau_pkg and mau_seq
//
// channel  direction  handshake            word
// in       input      in_valid/in_stall    in_word (op, gyro and accel counts)
// out      output     out_valid/out_stall  out_word (quaternion, Q2.30)
// cfg      input      cfg_valid/cfg_ready  cfg_index, cfg_data
//
// an update word runs its steps one after another on the serial arithmetic unit:
// 37 multiplies at 34 bits, 7 divides at 64 bits, 2 roots at 32 digits, one per cycle
// each of the 46 steps has an issue state and a wait for the done pulse
// a load word only sets the attitude from the init registers; one word is in work at a time
// reset gives kp 16777, drift -100/100/30 and the unit quaternion; no clearing pass
// a finished word sits in the output register; the next result waits while it is stalled

module mahony_attitude_update (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  mau_pkg::in_word_t  in_word,
	output logic               out_valid,
	input  logic               out_stall,
	output mau_pkg::out_word_t out_word,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [31:0]        cfg_data
);
	import mau_pkg::*;

	cfg_regs_t cfg_q;
	seq_rsp_t sr;
	out_word_t result;
	logic out_valid_q;
	out_word_t out_word_q;
	logic out_free;
	logic start;

	assign cfg_ready = 1'b1;
	assign in_stall = sr.busy;
	assign start = in_valid && !sr.busy;
	assign out_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_word = out_word_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.gain_kp <= 24'd16777;
			cfg_q.drift_x <= -16'sd100;
			cfg_q.drift_y <= 16'sd100;
			cfg_q.drift_z <= 16'sd30;
			cfg_q.init_w <= ONE_32;
			cfg_q.init_i <= '0;
			cfg_q.init_j <= '0;
			cfg_q.init_k <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_GAIN_KP: cfg_q.gain_kp <= cfg_data[23:0];
				CFG_DRIFT_X: cfg_q.drift_x <= cfg_data[15:0];
				CFG_DRIFT_Y: cfg_q.drift_y <= cfg_data[15:0];
				CFG_DRIFT_Z: cfg_q.drift_z <= cfg_data[15:0];
				CFG_INIT_W: cfg_q.init_w <= cfg_data;
				CFG_INIT_I: cfg_q.init_i <= cfg_data;
				CFG_INIT_J: cfg_q.init_j <= cfg_data;
				CFG_INIT_K: cfg_q.init_k <= cfg_data;
				default: cfg_q.init_k <= cfg_q.init_k;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sr.fin) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sr.fin) begin
			out_word_q <= result;
		end
	end

	mau_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.in_word  (in_word),
		.cfg      (cfg_q),
		.out_free (out_free),
		.sr       (sr),
		.result   (result)
	);

endmodule
